/* rtl/acs_pkg.sv */
// Package for the accumulator machine step block.
// Holds transaction types, operation and opcode codes, and the microcode ROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

    localparam logic [1:0] OPN_WRITE   = 2'd0;
    localparam logic [1:0] OPN_STEP    = 2'd1;
    localparam logic [1:0] OPN_RESTART = 2'd2;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [7:0] START_RESET = 8'd80;
    localparam logic [7:0] LIMIT_RESET = 8'd32;

    localparam logic [7:0] OP_JMP      = 8'h10;
    localparam logic [7:0] OP_JMPN     = 8'h11;
    localparam logic [7:0] OP_JMPZ     = 8'h12;
    localparam logic [7:0] OP_JMP_LAST = 8'h1F;
    localparam logic [7:0] OP_LD_I     = 8'h00;
    localparam logic [7:0] OP_ADD_I    = 8'h20;
    localparam logic [7:0] OP_SUB_I    = 8'h21;
    localparam logic [7:0] OP_NAND_I   = 8'h22;
    localparam logic [7:0] OP_LD_D     = 8'h40;
    localparam logic [7:0] OP_OUT_D    = 8'h41;
    localparam logic [7:0] OP_STA_D    = 8'h48;
    localparam logic [7:0] OP_STI_D    = 8'h49;
    localparam logic [7:0] OP_ADD_D    = 8'h60;
    localparam logic [7:0] OP_SUB_D    = 8'h61;
    localparam logic [7:0] OP_NAND_D   = 8'h62;
    localparam logic [7:0] OP_LD_X     = 8'hC0;
    localparam logic [7:0] OP_OUT_X    = 8'hC1;
    localparam logic [7:0] OP_STA_X    = 8'hC8;
    localparam logic [7:0] OP_STI_X    = 8'hC9;
    localparam logic [7:0] OP_ADD_X    = 8'hE0;
    localparam logic [7:0] OP_SUB_X    = 8'hE1;
    localparam logic [7:0] OP_NAND_X   = 8'hE2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] address;
        logic [7:0] data;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] pc;
        logic [7:0] acc;
        logic       out_valid;
        logic [7:0] out_value;
        logic       input_taken;
    } out_t;

    typedef enum logic [2:0] {
        CL_JMP, CL_IMM, CL_DIR, CL_IND, CL_BAD
    } cls_t;

    typedef enum logic [2:0] {
        FN_LOAD, FN_ADD, FN_SUB, FN_NAND, FN_OUT, FN_STA, FN_STI, FN_NONE
    } fn_t;

    typedef enum logic [2:0] {
        AS_PC, AS_PC1, AS_MDR, AS_ARG, AS_PTR, AS_REQ
    } addr_sel_t;

    typedef enum logic [2:0] {
        EX_NONE, EX_DECODE, EX_DIR, EX_IND, EX_SIMPLE
    } exec_t;

    typedef enum logic [1:0] {
        SQ_NEXT, SQ_JUMP, SQ_DISPATCH, SQ_DONE
    } seq_t;

    typedef logic [2:0] upc_t;

    localparam upc_t U_FETCH    = 3'd0;
    localparam upc_t U_OPERAND  = 3'd1;
    localparam upc_t U_DECODE   = 3'd2;
    localparam upc_t U_DIRECT   = 3'd3;
    localparam upc_t U_POINTER  = 3'd4;
    localparam upc_t U_INDIRECT = 3'd5;
    localparam upc_t U_SIMPLE   = 3'd6;

    typedef struct packed {
        addr_sel_t asel;
        logic      rd;
        logic      ld_op;
        logic      ld_arg;
        logic      ld_ptr;
        logic      pc_inc;
        exec_t     ex;
        seq_t      seq;
        upc_t      target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input upc_t a);
        ucode_t w;
        w = '{asel: AS_REQ, rd: 1'b0, ld_op: 1'b0, ld_arg: 1'b0, ld_ptr: 1'b0,
              pc_inc: 1'b0, ex: EX_NONE, seq: SQ_DONE, target: U_FETCH};
        case (a)
            U_FETCH: begin
                w.asel = AS_PC;
                w.rd   = 1'b1;
                w.seq  = SQ_NEXT;
            end
            U_OPERAND: begin
                w.asel   = AS_PC1;
                w.rd     = 1'b1;
                w.ld_op  = 1'b1;
                w.pc_inc = 1'b1;
                w.seq    = SQ_NEXT;
            end
            U_DECODE: begin
                w.asel   = AS_MDR;
                w.rd     = 1'b1;
                w.ld_arg = 1'b1;
                w.ex     = EX_DECODE;
                w.seq    = SQ_DISPATCH;
            end
            U_DIRECT: begin
                w.asel = AS_ARG;
                w.ex   = EX_DIR;
            end
            U_POINTER: begin
                w.asel   = AS_MDR;
                w.rd     = 1'b1;
                w.ld_ptr = 1'b1;
                w.seq    = SQ_JUMP;
                w.target = U_INDIRECT;
            end
            U_INDIRECT: begin
                w.asel = AS_PTR;
                w.ex   = EX_IND;
            end
            default: begin
                w.ex = EX_SIMPLE;
            end
        endcase
        return w;
    endfunction

    function automatic cls_t op_class(input logic [7:0] op);
        cls_t c;
        unique case (op) inside
            [OP_JMP:OP_JMP_LAST]:                          c = CL_JMP;
            OP_LD_I, OP_ADD_I, OP_SUB_I, OP_NAND_I:        c = CL_IMM;
            OP_LD_D, OP_OUT_D, OP_STA_D, OP_STI_D,
            OP_ADD_D, OP_SUB_D, OP_NAND_D:                 c = CL_DIR;
            OP_LD_X, OP_OUT_X, OP_STA_X, OP_STI_X,
            OP_ADD_X, OP_SUB_X, OP_NAND_X:                 c = CL_IND;
            default:                                       c = CL_BAD;
        endcase
        return c;
    endfunction

    function automatic fn_t op_fn(input logic [7:0] op);
        fn_t f;
        unique case (op) inside
            OP_LD_I, OP_LD_D, OP_LD_X:       f = FN_LOAD;
            OP_ADD_I, OP_ADD_D, OP_ADD_X:    f = FN_ADD;
            OP_SUB_I, OP_SUB_D, OP_SUB_X:    f = FN_SUB;
            OP_NAND_I, OP_NAND_D, OP_NAND_X: f = FN_NAND;
            OP_OUT_D, OP_OUT_X:              f = FN_OUT;
            OP_STA_D, OP_STA_X:              f = FN_STA;
            OP_STI_D, OP_STI_X:              f = FN_STI;
            default:                         f = FN_NONE;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* rtl/acs_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module acs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/accumulator_cpu_step_top.sv */
// Top level of the accumulator machine step block: sequencer, datapath and store.
// Depends on acs_pkg and acs_ram.
`timescale 1ns / 1ps
`default_nettype none

// Each transaction runs alone through a microcoded sequencer that walks the
// single-port store, one read per cycle with registered read data. A write, a
// restart or a step while halted or faulted runs only the simple step; a step with
// an immediate operand, a jump or an unknown opcode runs fetch, operand and decode,
// a direct operand adds the direct step, an indirect one the pointer and indirect
// steps. s_ready is low while a transaction is in work. A finished result waits in
// the output register; the next one holds at its last step until it is taken. The
// store reads as zero after reset via per-byte valid flags, so needs no clearing.
module accumulator_cpu_step_top
    import acs_pkg::*;
#(
    parameter int MEM_DEPTH = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data,
    input  wire logic       cfg_we,
    input  wire logic       cfg_addr,
    input  wire logic [7:0] cfg_wdata
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic                 busy_reg;
    upc_t                 upc_reg;
    in_t                  req_reg;
    logic [7:0]           pc_reg;
    logic [7:0]           acc_reg;
    logic [1:0]           status_reg;
    logic [7:0]           op_reg;
    logic [7:0]           arg_reg;
    logic [7:0]           ptr_reg;
    logic [7:0]           start_reg;
    logic [7:0]           limit_reg;
    logic [MEM_DEPTH-1:0] vld_reg;
    logic                 vld_rd_reg;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    ucode_t     uw;
    cls_t       cls;
    fn_t        fn;
    logic [7:0] mdr;
    logic [7:0] ram_rdata;
    logic [7:0] mem_addr;
    logic       accept;
    logic       out_free;
    logic       final_step;
    logic       advance;
    logic       ram_we;
    logic       ram_re;
    logic       store_we;
    logic [7:0] store_data;
    logic [7:0] pc_next;
    logic [7:0] acc_next;
    logic [1:0] status_next;
    logic       ov;
    logic       taken;
    upc_t       upc_next;
    logic       go;

    assign uw       = ucode_rom(upc_reg);
    assign cls      = op_class(op_reg);
    assign fn       = op_fn(op_reg);
    assign mdr      = vld_rd_reg ? ram_rdata : 8'd0;
    assign accept   = s_valid && !busy_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign final_step = busy_reg && ((uw.seq == SQ_DONE) ||
        ((uw.seq == SQ_DISPATCH) && (cls != CL_DIR) && (cls != CL_IND)));
    assign advance = busy_reg && (!final_step || out_free);

    always_comb begin
        unique case (uw.asel)
            AS_PC:   mem_addr = pc_reg;
            AS_PC1:  mem_addr = pc_reg + 8'd1;
            AS_MDR:  mem_addr = mdr;
            AS_ARG:  mem_addr = arg_reg;
            AS_PTR:  mem_addr = ptr_reg;
            default: mem_addr = req_reg.address;
        endcase
    end

    always_comb begin
        pc_next     = pc_reg;
        acc_next    = acc_reg;
        status_next = status_reg;
        ov          = 1'b0;
        taken       = 1'b0;
        store_we    = 1'b0;
        store_data  = acc_reg;
        go          = (op_reg == OP_JMP) || ((op_reg == OP_JMPN) && acc_reg[7]) ||
                      ((op_reg == OP_JMPZ) && (acc_reg == 8'd0));
        unique case (uw.ex)
            EX_SIMPLE: begin
                case (req_reg.operation)
                    OPN_WRITE: begin
                        store_we   = 1'b1;
                        store_data = req_reg.data;
                    end
                    OPN_RESTART: begin
                        pc_next     = start_reg;
                        acc_next    = 8'd0;
                        status_next = ST_RUN;
                    end
                    default: ;
                endcase
            end
            EX_DECODE, EX_DIR, EX_IND: begin
                if (cls == CL_JMP) begin
                    pc_next = go ? mdr : pc_reg + 8'd1;
                end else if (cls != CL_BAD) begin
                    pc_next = pc_reg + 8'd1;
                    case (fn)
                        FN_LOAD: acc_next = mdr;
                        FN_ADD:  acc_next = acc_reg + mdr;
                        FN_SUB:  acc_next = acc_reg - mdr;
                        FN_NAND: acc_next = ~(acc_reg & mdr);
                        FN_OUT:  ov = 1'b1;
                        FN_STA:  store_we = 1'b1;
                        FN_STI: begin
                            store_we   = 1'b1;
                            store_data = req_reg.data;
                            taken      = 1'b1;
                        end
                        default: ;
                    endcase
                end
                if (cls == CL_BAD) begin
                    status_next = ST_FAULT;
                end else if (pc_next == 8'd0) begin
                    status_next = ST_HALT;
                end else if (pc_next < limit_reg) begin
                    status_next = ST_FAULT;
                end else begin
                    status_next = ST_RUN;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (uw.seq)
            SQ_NEXT:     upc_next = upc_reg + 3'd1;
            SQ_JUMP:     upc_next = uw.target;
            SQ_DISPATCH: upc_next = (cls == CL_IND) ? U_POINTER : U_DIRECT;
            default:     upc_next = upc_reg;
        endcase
    end

    assign ram_we = final_step && advance && store_we;
    assign ram_re = advance && uw.rd;

    acs_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (mem_addr[AW-1:0]),
        .wdata (store_data),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            upc_reg     <= U_FETCH;
            pc_reg      <= START_RESET;
            acc_reg     <= 8'd0;
            status_reg  <= ST_RUN;
            start_reg   <= START_RESET;
            limit_reg   <= LIMIT_RESET;
            vld_reg     <= '0;
            vld_rd_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_START: start_reg <= cfg_wdata;
                    default:   limit_reg <= cfg_wdata;
                endcase
            end
            if (ram_we) begin
                vld_reg[mem_addr[AW-1:0]] <= 1'b1;
            end
            if (ram_re) begin
                vld_rd_reg <= vld_reg[mem_addr[AW-1:0]];
            end
            if (accept) begin
                busy_reg <= 1'b1;
                if ((s_data.operation == OPN_STEP) && (status_reg == ST_RUN)) begin
                    upc_reg <= U_FETCH;
                end else begin
                    upc_reg <= U_SIMPLE;
                end
            end else if (advance) begin
                if (final_step) begin
                    busy_reg   <= 1'b0;
                    pc_reg     <= pc_next;
                    acc_reg    <= acc_next;
                    status_reg <= status_next;
                end else begin
                    upc_reg <= upc_next;
                    if (uw.pc_inc) begin
                        pc_reg <= pc_reg + 8'd1;
                    end
                end
            end
            if (final_step && advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        if (advance && uw.ld_op) begin
            op_reg <= mdr;
        end
        if (advance && uw.ld_arg) begin
            arg_reg <= mdr;
        end
        if (advance && uw.ld_ptr) begin
            ptr_reg <= mdr;
        end
        if (final_step && advance) begin
            m_data_reg.status      <= status_next;
            m_data_reg.pc          <= pc_next;
            m_data_reg.acc         <= acc_next;
            m_data_reg.out_valid   <= ov;
            m_data_reg.out_value   <= ov ? mdr : 8'd0;
            m_data_reg.input_taken <= taken;
        end
    end

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
